### sv/sha256_pkg.sv
package sha256_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int POS_W       = $clog2(BLOCK_BYTES);
  localparam int LEN_OFFSET  = BLOCK_BYTES - 8;
  localparam int ROUNDS      = 64;
  localparam int ROUND_W     = $clog2(ROUNDS);

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] vars_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic  push;
    logic  step;
    word_t word;
  } sched_ctl_t;

  localparam vars_t HASH_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return word_t'((x >> n) | (x << (32 - n)));
  endfunction

  function automatic word_t big_sig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### sv/sha256_round.sv
module sha256_round
  import sha256_pkg::*;
(
  input  vars_t vars,
  input  word_t k,
  input  word_t w,
  output vars_t vars_next
);

  word_t t1;
  word_t t2;
  word_t choose;
  word_t major;

  always_comb begin
    choose = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    major  = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t1     = vars[7] + big_sig1(vars[4]) + choose + k + w;
    t2     = big_sig0(vars[0]) + major;
    vars_next[0] = t1 + t2;
    vars_next[1] = vars[0];
    vars_next[2] = vars[1];
    vars_next[3] = vars[2];
    vars_next[4] = vars[3] + t1;
    vars_next[5] = vars[4];
    vars_next[6] = vars[5];
    vars_next[7] = vars[6];
  end

endmodule

### sv/sha256_sched.sv
module sha256_sched
  import sha256_pkg::*;
(
  input  logic       clk,
  input  sched_ctl_t ctl,
  output word_t      w_cur
);

  // 16-word window, entry 0 is the word of the current round
  word_t win [16];
  word_t w_new;

  assign w_new = small_sig1(win[14]) + win[9] + small_sig0(win[1]) + win[0];
  assign w_cur = win[0];

  always_ff @(posedge clk) begin
    if (ctl.push || ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= ctl.step ? w_new : ctl.word;
    end
  end

endmodule

### sv/sha256_stream_hasher.sv
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+---------------------------------------
// in       | input     | in_valid / in_ready | message_byte, byte_present, message_end
// out      | output    | out_valid/out_ready | digest_word, word_index, digest_last
//
// a byte item is written into the block; the byte that fills a block also runs 64 rounds + add
// a final item pads one byte per cycle (up to 72 bytes), runs one or two compressions of
// 64 rounds + add each, then holds 8 digest items, one per cycle while out_ready is high
// in_ready is low from the block-filling byte until the round unit and add are done
// reset is synchronous; no memory clearing pass
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  message_byte,
  input  logic        byte_present,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_last
);

  state_t             state;
  state_t             state_next;
  logic [ROUND_W-1:0] round_ctr;
  logic [POS_W-1:0]   pos;
  logic [23:0]        acc;
  logic [60:0]        byte_count;
  vars_t              hash;
  vars_t              vars;
  vars_t              vars_next;
  logic               pending_end;
  logic               pad_mode;
  logic               pad_first;
  logic               len_ok;
  logic [2:0]         out_idx;

  logic               accept_in;
  logic               accept_out;
  logic               wr_en;
  logic [7:0]         wr_byte;
  logic [7:0]         len_byte;
  logic [63:0]        bit_len;
  logic               pos_last;
  sched_ctl_t         sched_ctl;
  word_t              w_cur;

  assign accept_in  = in_valid && in_ready;
  assign accept_out = out_valid && out_ready;
  assign pos_last   = (pos == POS_W'(BLOCK_BYTES - 1));
  assign bit_len    = {byte_count, 3'b000};
  assign len_byte   = bit_len[{~pos[2:0], 3'b000} +: 8];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_in) begin
          if (byte_present && pos_last) begin
            state_next = ST_ROUND;
          end else if (message_end) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (round_ctr == ROUND_W'(ROUNDS - 1)) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (pad_mode) begin
          state_next = len_ok ? ST_OUT : ST_PAD;
        end else begin
          state_next = pending_end ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        if (pos_last) begin
          state_next = ST_ROUND;
        end
      end
      ST_OUT: begin
        if (out_ready && out_idx == 3'd7) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and byte path control
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    wr_en     = 1'b0;
    wr_byte   = message_byte;
    case (state)
      ST_IDLE: begin
        wr_en = in_valid && byte_present;
      end
      ST_PAD: begin
        wr_en = 1'b1;
        if (pad_first) begin
          wr_byte = PAD_BYTE;
        end else if (len_ok && pos >= POS_W'(LEN_OFFSET)) begin
          wr_byte = len_byte;
        end else begin
          wr_byte = 8'h00;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    sched_ctl.push = wr_en && (pos[1:0] == 2'b11);
    sched_ctl.step = (state == ST_ROUND);
    sched_ctl.word = {acc, wr_byte};
  end

  assign digest_word = hash[out_idx];
  assign word_index  = out_idx;
  assign digest_last = (out_idx == 3'd7);

  sha256_sched u_sched (
    .clk   (clk),
    .ctl   (sched_ctl),
    .w_cur (w_cur)
  );

  sha256_round u_round (
    .vars      (vars),
    .k         (ROUND_K[round_ctr]),
    .w         (w_cur),
    .vars_next (vars_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      round_ctr   <= '0;
      pos         <= '0;
      byte_count  <= '0;
      hash        <= HASH_IV;
      pending_end <= 1'b0;
      pad_mode    <= 1'b0;
      pad_first   <= 1'b0;
      len_ok      <= 1'b0;
      out_idx     <= '0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        pos <= pos + 1'b1;
      end
      if (accept_in && byte_present) begin
        byte_count <= byte_count + 1'b1;
      end
      if (accept_in && byte_present && pos_last) begin
        pending_end <= message_end;
      end
      if (state != ST_PAD && state_next == ST_PAD && !pad_mode) begin
        pad_mode  <= 1'b1;
        pad_first <= 1'b1;
      end
      if (state == ST_PAD) begin
        pad_first <= 1'b0;
        if (pad_first && pos < POS_W'(LEN_OFFSET)) begin
          len_ok <= 1'b1;
        end
      end
      if (state != ST_ROUND && state_next == ST_ROUND) begin
        round_ctr <= '0;
      end else if (state == ST_ROUND) begin
        round_ctr <= round_ctr + 1'b1;
      end
      if (state == ST_FINAL) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + vars[i];
        end
        pending_end <= 1'b0;
        if (pad_mode && !len_ok) begin
          len_ok <= 1'b1;
        end
      end
      if (accept_out) begin
        out_idx <= out_idx + 1'b1;
        if (out_idx == 3'd7) begin
          hash       <= HASH_IV;
          byte_count <= '0;
          pos        <= '0;
          pad_mode   <= 1'b0;
          len_ok     <= 1'b0;
        end
      end
    end
  end

  // partial word and working variables
  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc <= {acc[15:0], wr_byte};
    end
    if (state != ST_ROUND && state_next == ST_ROUND) begin
      vars <= hash;
    end else if (state == ST_ROUND) begin
      vars <= vars_next;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");

  a_round_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && round_ctr == ROUND_W'(ROUNDS - 1)) |=> (state == ST_FINAL))
    else $error("compression did not finish after last round");

  a_out_block_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pos == '0 && pad_mode && len_ok))
    else $error("digest shown before final block");

  a_reinit: assert property (@(posedge clk) disable iff (rst)
    (accept_out && digest_last) |=> (byte_count == '0 && hash == HASH_IV && in_ready))
    else $error("hash state not re-initialized after digest");

endmodule
